// ===== design/cact_pkg.sv =====
// shared types and constants for the class attribute count table
`timescale 1ns / 1ps
package cact_pkg;

  localparam int CMD_W    = 3;
  localparam int LABEL_W  = 3;
  localparam int ATTR_W   = 4;
  localparam int VALUE_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 24;
  localparam int MASK_W   = 16;

  localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_JOINT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_VALUE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_LABEL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIST_VALUES = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DIST_LABELS = 3'd6;

  localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_NOMINAL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW    = 2'd3;

  localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic clr_wr;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic clr_last;
  } sts_t;

endpackage

// ===== design/cact_if.sv =====
// channel interfaces for items, results and configuration
`timescale 1ns / 1ps
interface cact_item_if;
  logic                          valid;
  logic                          ready;
  logic [cact_pkg::CMD_W-1:0]    command;
  logic [cact_pkg::LABEL_W-1:0]  label;
  logic [cact_pkg::ATTR_W-1:0]   attr_index;
  logic [cact_pkg::VALUE_W-1:0]  attr_value;
  logic                          count_label;
  modport source (output valid, command, label, attr_index, attr_value, count_label,
                  input ready);
  modport sink (input valid, command, label, attr_index, attr_value, count_label,
                output ready);
endinterface

interface cact_result_if;
  logic                           valid;
  logic                           ready;
  logic [cact_pkg::STATUS_W-1:0]  status;
  logic [cact_pkg::COUNT_W-1:0]   count;
  modport source (output valid, status, count, input ready);
  modport sink (input valid, status, count, output ready);
endinterface

interface cact_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cact_pkg::MASK_W-1:0]  nominal_mask;
  modport source (output valid, nominal_mask, input ready);
  modport sink (input valid, nominal_mask, output ready);
endinterface

// ===== design/cact_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cact_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cact_ctrl.sv =====
// controller state machine for the class attribute count table
`timescale 1ns / 1ps
module cact_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cact_pkg::sts_t  sts,
  output cact_pkg::ctl_t  ctl
);

  cact_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cact_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cact_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_next = cact_pkg::ST_IDLE;
      end
      cact_pkg::ST_IDLE: begin
        if (in_valid) state_next = sts.need_scan ? cact_pkg::ST_SCAN : cact_pkg::ST_DONE;
      end
      cact_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = cact_pkg::ST_DRAIN;
      end
      cact_pkg::ST_DRAIN: begin
        state_next = cact_pkg::ST_DONE;
      end
      cact_pkg::ST_DONE: begin
        if (out_free) state_next = cact_pkg::ST_IDLE;
      end
      default: state_next = cact_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      cact_pkg::ST_CLEAR: ctl.clr_wr = 1'b1;
      cact_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      cact_pkg::ST_SCAN:  ctl.scan_rd = 1'b1;
      cact_pkg::ST_DRAIN: ;
      cact_pkg::ST_DONE:  ctl.finish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/cact_datapath.sv =====
// count stores, update checks and result register
`timescale 1ns / 1ps
module cact_datapath #(
  parameter int NUM_ATTRS   = 16,
  parameter int LABEL_SLOTS = 8,
  parameter int VALUE_SLOTS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cact_pkg::CMD_W-1:0]     command,
  input  logic [cact_pkg::LABEL_W-1:0]   label,
  input  logic [cact_pkg::ATTR_W-1:0]    attr_index,
  input  logic [cact_pkg::VALUE_W-1:0]   attr_value,
  input  logic                           count_label,
  input  logic                           cfg_we,
  input  logic [cact_pkg::MASK_W-1:0]    cfg_data,
  input  cact_pkg::ctl_t                 ctl,
  output cact_pkg::sts_t                 sts,
  output logic [cact_pkg::STATUS_W-1:0]  res_status,
  output logic [cact_pkg::COUNT_W-1:0]   res_count
);

  localparam int AW       = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
  localparam int LW       = $clog2(LABEL_SLOTS);
  localparam int VW       = $clog2(VALUE_SLOTS);
  localparam int JW       = AW + LW + VW;
  localparam int XW       = AW + VW;
  localparam int SLOT_MAX = (VALUE_SLOTS > LABEL_SLOTS) ? VALUE_SLOTS : LABEL_SLOTS;
  localparam int IW       = $clog2(SLOT_MAX);
  localparam int SW       = $clog2(SLOT_MAX + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [cact_pkg::CMD_W-1:0]    cmd_q;
  logic [cact_pkg::LABEL_W-1:0]  label_q;
  logic [cact_pkg::ATTR_W-1:0]   attr_q;
  logic [cact_pkg::VALUE_W-1:0]  value_q;
  logic                          flag_q;
  logic [cact_pkg::MASK_W-1:0]   mask;
  logic [IW-1:0]                 idx;
  logic [SW-1:0]                 acc;
  logic                          pend;
  logic [JW-1:0]                 clr_addr;

  logic nom_in, nom_q, lbad, vbad, up, bad_move;
  logic j_lim, v_lim, l_lim, upd_jv, upd_l, scan_hit;
  logic [COUNT_BITS-1:0] jc, vc, lc, jn, vn, ln;
  logic [JW-1:0] j_raddr, j_waddr;
  logic [XW-1:0] v_raddr, v_waddr;
  logic [LW-1:0] l_raddr, l_waddr;
  logic j_we, v_we, l_we, v_re;
  logic [cact_pkg::STATUS_W-1:0] st_calc;
  logic [cact_pkg::COUNT_W-1:0]  ct_calc;

  assign nom_in = (int'(attr_index) < NUM_ATTRS) && mask[attr_index];
  assign nom_q  = (int'(attr_q) < NUM_ATTRS) && mask[attr_q];

  assign sts.need_scan = (command == cact_pkg::CMD_DIST_LABELS)
                      || ((command == cact_pkg::CMD_DIST_VALUES) && nom_in);
  assign sts.scan_last = (cmd_q == cact_pkg::CMD_DIST_VALUES) ? (int'(idx) == VALUE_SLOTS - 1)
                                                              : (int'(idx) == LABEL_SLOTS - 1);
  assign sts.clr_last  = &clr_addr;

  // read addresses: item fields at accept, walk index while scanning
  assign j_raddr = {AW'(attr_index), LW'(label), VW'(attr_value)};
  assign v_raddr = ctl.scan_rd ? {AW'(attr_q), VW'(idx)} : {AW'(attr_index), VW'(attr_value)};
  assign l_raddr = ctl.scan_rd ? LW'(idx) : LW'(label);
  assign v_re    = ctl.accept || ctl.scan_rd;

  assign j_waddr = ctl.clr_wr ? clr_addr : {AW'(attr_q), LW'(label_q), VW'(value_q)};
  assign v_waddr = ctl.clr_wr ? clr_addr[XW-1:0] : {AW'(attr_q), VW'(value_q)};
  assign l_waddr = ctl.clr_wr ? clr_addr[LW-1:0] : LW'(label_q);

  assign lbad = int'(label_q) >= LABEL_SLOTS;
  assign vbad = int'(value_q) >= VALUE_SLOTS;
  assign up   = (cmd_q == cact_pkg::CMD_ADD);

  assign j_lim    = up ? (jc == CNT_MAX) : (jc == '0);
  assign v_lim    = up ? (vc == CNT_MAX) : (vc == '0);
  assign l_lim    = up ? (lc == CNT_MAX) : (lc == '0);
  assign bad_move = (nom_q && (j_lim || v_lim)) || (flag_q && l_lim);

  assign jn = ctl.clr_wr ? '0 : (up ? jc + COUNT_BITS'(1) : jc - COUNT_BITS'(1));
  assign vn = ctl.clr_wr ? '0 : (up ? vc + COUNT_BITS'(1) : vc - COUNT_BITS'(1));
  assign ln = ctl.clr_wr ? '0 : (up ? lc + COUNT_BITS'(1) : lc - COUNT_BITS'(1));

  assign j_we = ctl.clr_wr || (ctl.finish && upd_jv);
  assign v_we = ctl.clr_wr || (ctl.finish && upd_jv);
  assign l_we = ctl.clr_wr || (ctl.finish && upd_l);

  always_comb begin
    st_calc = cact_pkg::STAT_OK;
    ct_calc = '0;
    upd_jv  = 1'b0;
    upd_l   = 1'b0;
    case (cmd_q) inside
      cact_pkg::CMD_ADD, cact_pkg::CMD_REMOVE: begin
        if (lbad || (nom_q && vbad)) begin
          st_calc = cact_pkg::STAT_NOT_NOMINAL;
        end else if (bad_move) begin
          st_calc = up ? cact_pkg::STAT_OVERFLOW : cact_pkg::STAT_UNDERFLOW;
        end else begin
          upd_jv = nom_q;
          upd_l  = flag_q;
          if (!nom_q) st_calc = cact_pkg::STAT_NOT_NOMINAL;
        end
      end
      cact_pkg::CMD_READ_JOINT: begin
        if (!nom_q || lbad || vbad) st_calc = cact_pkg::STAT_NOT_NOMINAL;
        else ct_calc = cact_pkg::COUNT_W'(jc);
      end
      cact_pkg::CMD_READ_VALUE: begin
        if (!nom_q || vbad) st_calc = cact_pkg::STAT_NOT_NOMINAL;
        else ct_calc = cact_pkg::COUNT_W'(vc);
      end
      cact_pkg::CMD_READ_LABEL: begin
        if (lbad) st_calc = cact_pkg::STAT_NOT_NOMINAL;
        else ct_calc = cact_pkg::COUNT_W'(lc);
      end
      cact_pkg::CMD_DIST_VALUES: begin
        if (!nom_q) st_calc = cact_pkg::STAT_NOT_NOMINAL;
        else ct_calc = cact_pkg::COUNT_W'(acc);
      end
      cact_pkg::CMD_DIST_LABELS: ct_calc = cact_pkg::COUNT_W'(acc);
      default: ;
    endcase
  end

  assign scan_hit = (cmd_q == cact_pkg::CMD_DIST_VALUES) ? (vc != '0) : (lc != '0);

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q   <= command;
      label_q <= label;
      attr_q  <= attr_index;
      value_q <= attr_value;
      flag_q  <= count_label;
      idx     <= '0;
      acc     <= '0;
    end else begin
      if (ctl.scan_rd) idx <= idx + IW'(1);
      if (pend && scan_hit) acc <= acc + SW'(1);
    end
    if (ctl.finish) begin
      res_status <= st_calc;
      res_count  <= ct_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= cact_pkg::MASK_RESET;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      if (cfg_we) mask <= cfg_data;
      if (ctl.clr_wr) clr_addr <= clr_addr + JW'(1);
      pend <= ctl.scan_rd;
    end
  end

  cact_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << JW)) u_joint (
    .clk(clk), .we(j_we), .waddr(j_waddr), .wdata(jn),
    .re(ctl.accept), .raddr(j_raddr), .rdata(jc)
  );

  cact_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << XW)) u_value (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(vn),
    .re(v_re), .raddr(v_raddr), .rdata(vc)
  );

  cact_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << LW)) u_label (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(ln),
    .re(v_re), .raddr(l_raddr), .rdata(lc)
  );

endmodule

// ===== design/class_attribute_count_table.sv =====
// top level of the class attribute count table
//
//   channel  modport  beat carries
//   item     sink     command, label, attr_index, attr_value, count_label
//   result   source   status, count
//   cfg      sink     nominal_mask (always ready)
//
// add, remove and single reads accept with the ram read, then check and write back
// distinct queries scan the slots, one stored count read per cycle from the value
// or label ram
// after reset a clearing pass over 2^(attr bits + label bits + value bits) addresses (2048 by
// default) zeroes the rams; items are held off, cfg beats are taken
// a new item is accepted while a result waits; it holds in its last cycle until the result
// register is free
`timescale 1ns / 1ps
module class_attribute_count_table #(
  parameter int NUM_ATTRS   = 16,
  parameter int LABEL_SLOTS = 8,
  parameter int VALUE_SLOTS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic           clk,
  input  logic           rst,
  cact_item_if.sink      item,
  cact_result_if.source  result,
  cact_cfg_if.sink       cfg
);

  cact_pkg::ctl_t ctl;
  cact_pkg::sts_t sts;
  logic cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  cact_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .sts(sts),
    .ctl(ctl)
  );

  cact_datapath #(
    .NUM_ATTRS(NUM_ATTRS),
    .LABEL_SLOTS(LABEL_SLOTS),
    .VALUE_SLOTS(VALUE_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .command(item.command),
    .label(item.label),
    .attr_index(item.attr_index),
    .attr_value(item.attr_value),
    .count_label(item.count_label),
    .cfg_we(cfg_we),
    .cfg_data(cfg.nominal_mask),
    .ctl(ctl),
    .sts(sts),
    .res_status(result.status),
    .res_count(result.count)
  );

  a_finish_not_accept: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !ctl.accept)
    else $error("write back overlaps an item beat");

  a_clear_blocks_items: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_wr |-> !item.ready)
    else $error("item ready during clearing pass");

  a_error_count_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != cact_pkg::STAT_OK)) |-> (result.count == '0))
    else $error("nonzero count with error status");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item ready right after a beat");

endmodule
